// ===== hdl/esf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esf_pkg;

	// one result row as it leaves the block
	typedef struct packed {
		logic [7:0] row_number;
		logic [7:0] left_filtered;
		logic [7:0] right_filtered;
		logic       last_row;
	} result_t;

	localparam logic [7:0] THR_RESET = 8'd5;
	localparam logic [7:0] ROW_MAX   = 8'd255;

	// output queue: power-of-two depth, room for the two results of a frame end
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef logic [QUEUE_AW-1:0] qptr_t;
	typedef logic [QUEUE_AW:0]   qlevel_t;

	// what the merge stage hands to the output queue in one cycle
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t data0;
		result_t data1;
	} qpush_t;

endpackage

`default_nettype wire

// ===== hdl/edge_spike_suppress_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a row's result enters the output queue when the next row's item is accepted
// a frame-end item queues the held row and itself at its accept, the held row leaving first
// throughput: one item per cycle while the input is not stalled, set by the 4-entry output queue;
//   a frame end queues two results, and the input stalls while more than two results wait
// reset: asynchronous, active low; queue emptied, rows cleared, threshold back to 5

module edge_spike_suppress_filter_top #(
	parameter int FIRST_ROW   = 4,
	parameter int END_ROW     = 50,
	parameter int COLUMN_BITS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration: threshold register
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	// input items
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] left_edge,
	input  wire logic [7:0] right_edge,
	input  wire logic       frame_end,
	// result items
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      row_number,
	output logic [7:0]      left_filtered,
	output logic [7:0]      right_filtered,
	output logic            last_row
);

	// columns beyond 8 bits never arrive, so storage stops at 8
	localparam int CW = (COLUMN_BITS < 8) ? COLUMN_BITS : 8;
	localparam logic [7:0] FIRST_C = 8'(FIRST_ROW);
	localparam logic [7:0] END_C   = 8'(END_ROW);

	logic [7:0]    thr_q;
	logic [CW-1:0] prev_l_q, prev_r_q;   // filtered row before the held row
	logic [CW-1:0] held_l_q, held_r_q;   // raw held row
	logic [7:0]    row_q;                // index of the held row
	logic          holding_q;

	logic             in_acc, out_acc;
	logic [CW-1:0]    nl, nr, fl, fr;
	logic             filt_en;
	logic [7:0]       new_row;
	esf_pkg::result_t ent_held, ent_new, head;
	esf_pkg::qpush_t  qwr;
	esf_pkg::qlevel_t level;

	// handshake
	assign in_stall = (level > esf_pkg::qlevel_t'(esf_pkg::QUEUE_DEPTH - 2));
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = (level != '0);
	assign out_acc  = out_valid && !out_stall;

	assign nl = left_edge[CW-1:0];
	assign nr = right_edge[CW-1:0];

	// only rows inside the window that now have a successor are filtered
	assign filt_en = holding_q && (row_q >= FIRST_C) && (row_q < END_C);

	// one lane per edge, independent of each other
	esf_lane #(.W(CW)) u_lane_left (
		.en     (filt_en),
		.thr    (thr_q),
		.pre    (prev_l_q),
		.cur    (held_l_q),
		.after  (nl),
		.res    (fl)
	);

	esf_lane #(.W(CW)) u_lane_right (
		.en     (filt_en),
		.thr    (thr_q),
		.pre    (prev_r_q),
		.cur    (held_r_q),
		.after  (nr),
		.res    (fr)
	);

	// merge: held row result first, then the frame-end row if any
	always_comb begin
		if (!holding_q) begin
			new_row = '0;
		end else if (row_q == esf_pkg::ROW_MAX) begin
			new_row = esf_pkg::ROW_MAX;   // counter saturates on long frames
		end else begin
			new_row = row_q + 8'd1;
		end

		ent_held.row_number     = row_q;
		ent_held.left_filtered  = 8'(fl);
		ent_held.right_filtered = 8'(fr);
		ent_held.last_row       = 1'b0;

		ent_new.row_number     = new_row;
		ent_new.left_filtered  = 8'(nl);
		ent_new.right_filtered = 8'(nr);
		ent_new.last_row       = 1'b1;

		if (holding_q) begin
			qwr.push0 = in_acc;
			qwr.data0 = ent_held;
			qwr.push1 = in_acc && frame_end;
			qwr.data1 = ent_new;
		end else begin
			qwr.push0 = in_acc && frame_end;
			qwr.data0 = ent_new;
			qwr.push1 = 1'b0;
			qwr.data1 = ent_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= esf_pkg::THR_RESET;
			prev_l_q  <= '0;
			prev_r_q  <= '0;
			held_l_q  <= '0;
			held_r_q  <= '0;
			row_q     <= '0;
			holding_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (in_acc) begin
				if (frame_end) begin
					// frame done, back to the empty state
					prev_l_q  <= '0;
					prev_r_q  <= '0;
					held_l_q  <= '0;
					held_r_q  <= '0;
					row_q     <= '0;
					holding_q <= 1'b0;
				end else begin
					if (holding_q) begin
						prev_l_q <= fl;
						prev_r_q <= fr;
					end
					held_l_q  <= nl;
					held_r_q  <= nr;
					row_q     <= new_row;
					holding_q <= 1'b1;
				end
			end
		end
	end

	esf_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (qwr),
		.pop    (out_acc),
		.head   (head),
		.level  (level)
	);

	assign row_number     = head.row_number;
	assign left_filtered  = head.left_filtered;
	assign right_filtered = head.right_filtered;
	assign last_row       = head.last_row;

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= esf_pkg::qlevel_t'(esf_pkg::QUEUE_DEPTH))
		else $error("output queue overflow");

	// a frame-end item leaves nothing held
	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && frame_end |=> !holding_q && row_q == '0)
		else $error("frame end did not clear row state");

	// with nothing held the row index and the stored previous row are zero
	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		!holding_q |-> row_q == '0 && prev_l_q == '0 && prev_r_q == '0)
		else $error("stale row state while nothing held");

	// an accepted item that must produce a result grows the queue unless a pop frees a slot
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (holding_q || frame_end) && !out_acc |=> level > $past(level))
		else $error("result not queued");

endmodule

`default_nettype wire

// ===== hdl/esf_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esf_lane #(
	parameter int W = 8
) (
	input  wire logic         en,
	input  wire logic [7:0]   thr,
	input  wire logic [W-1:0] pre,
	input  wire logic [W-1:0] cur,
	input  wire logic [W-1:0] after,
	output logic      [W-1:0] res
);

	localparam int CW = (W > 8) ? W : 8;

	logic [W-1:0] up_b, up_a, dn_b, dn_a;
	logic [W:0]   sum;
	logic         peak, valley;

	always_comb begin
		up_b = cur - pre;
		up_a = cur - after;
		dn_b = pre - cur;
		dn_a = after - cur;
		sum  = {1'b0, pre} + {1'b0, after};
		peak = (cur > pre) && (cur > after) &&
			(CW'(up_b) > CW'(thr)) && (CW'(up_a) > CW'(thr));
		valley = (cur < pre) && (cur < after) &&
			(CW'(dn_b) > CW'(thr)) && (CW'(dn_a) > CW'(thr));
		// floor mean of the filtered predecessor and raw successor
		if (en && (peak || valley)) begin
			res = sum[W:1];
		end else begin
			res = cur;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/esf_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esf_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire esf_pkg::qpush_t   wr,
	input  wire logic              pop,
	output esf_pkg::result_t       head,
	output esf_pkg::qlevel_t       level
);

	esf_pkg::result_t mem_q [esf_pkg::QUEUE_DEPTH];
	esf_pkg::qptr_t   wp_q, rp_q;
	esf_pkg::qlevel_t level_q;
	esf_pkg::qptr_t   wp_next1;
	logic [1:0]       n_push;

	always_comb begin
		wp_next1 = wp_q + esf_pkg::qptr_t'(1);
		n_push   = {1'b0, wr.push0} + {1'b0, wr.push1};
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (wr.push0) begin
			mem_q[wp_q] <= wr.data0;
		end
		if (wr.push1) begin
			mem_q[wp_next1] <= wr.data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= wp_q + esf_pkg::qptr_t'(n_push);
			rp_q    <= rp_q + esf_pkg::qptr_t'(pop);
			level_q <= level_q + esf_pkg::qlevel_t'(n_push) - esf_pkg::qlevel_t'(pop);
		end
	end

	assign head  = mem_q[rp_q];
	assign level = level_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int FIRST_ROW      = 4;
	localparam int END_ROW        = 50;
	localparam int LONG_HOLD      = 80;     // receiver hold-off used to back up the block
	localparam int SETTLE_CYCLES  = 4;      // covers a row still inside the block
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either side

	// one input item as the driver presents it
	typedef struct packed {
		logic [7:0] left_col;
		logic [7:0] right_col;
		logic       last_in_frame;
	} edge_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] left_edge = 8'd0;
	logic [7:0] right_edge = 8'd0;
	logic       frame_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] row_number;
	logic [7:0] left_filtered;
	logic [7:0] right_filtered;
	logic       last_row;

	// items waiting for the driver, results waiting for the checker
	edge_row_t        pending_rows[$];
	esf_pkg::result_t expected_rows[$];

	// idle knobs in percent of cycles, then the long-hold bookkeeping
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_requests = 0;
	int holds_done    = 0;
	int hold_left     = 0;

	// shadow of the filter state
	logic [7:0] thr_shadow = esf_pkg::THR_RESET;
	logic [7:0] prev_l = 8'd0, prev_r = 8'd0;
	logic [7:0] held_l = 8'd0, held_r = 8'd0;
	logic [7:0] row_idx = 8'd0;
	logic       row_held = 1'b0;

	int errors        = 0;
	int rows_sent     = 0;
	int rows_checked  = 0;
	int frames_closed = 0;
	int despiked      = 0;
	int thr_writes    = 0;
	int quiet_cycles  = 0;

	edge_spike_suppress_filter_top #(
		.FIRST_ROW  (FIRST_ROW),
		.END_ROW    (END_ROW),
		.COLUMN_BITS(8)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_edge     (left_edge),
		.right_edge    (right_edge),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.row_number    (row_number),
		.left_filtered (left_filtered),
		.right_filtered(right_filtered),
		.last_row      (last_row)
	);

	always #4 clk = ~clk;

	// a strict peak or valley beyond the threshold becomes the floor mean of its neighbors
	function automatic logic [7:0] despike(input logic [7:0] pre, input logic [7:0] cur,
			input logic [7:0] post);
		logic       peak;
		logic       valley;
		logic [8:0] sum;
		peak = cur > pre && cur > post && (cur - pre) > thr_shadow && (cur - post) > thr_shadow;
		valley = cur < pre && cur < post && (pre - cur) > thr_shadow && (post - cur) > thr_shadow;
		sum = {1'b0, pre} + {1'b0, post};
		return (peak || valley) ? sum[8:1] : cur;
	endfunction

	// advance the shadow state by one accepted row, queueing the results it releases
	task automatic filter_row(input edge_row_t r);
		esf_pkg::result_t res;
		logic [7:0]       next_idx;
		next_idx = 8'd0;
		if (row_held) begin
			res.row_number     = row_idx;
			res.left_filtered  = held_l;
			res.right_filtered = held_r;
			res.last_row       = 1'b0;
			// the held row only gets filtered inside the active window
			if (row_idx >= FIRST_ROW && row_idx < END_ROW) begin
				res.left_filtered  = despike(prev_l, held_l, r.left_col);
				res.right_filtered = despike(prev_r, held_r, r.right_col);
			end
			despiked += (res.left_filtered != held_l) + (res.right_filtered != held_r);
			expected_rows.push_back(res);
			prev_l   = res.left_filtered;
			prev_r   = res.right_filtered;
			next_idx = (row_idx == esf_pkg::ROW_MAX) ? esf_pkg::ROW_MAX : row_idx + 8'd1;
		end
		if (r.last_in_frame) begin
			// the closing row has no successor, so it leaves raw, and the frame state clears
			res.row_number     = next_idx;
			res.left_filtered  = r.left_col;
			res.right_filtered = r.right_col;
			res.last_row       = 1'b1;
			expected_rows.push_back(res);
			prev_l   = 8'd0;
			prev_r   = 8'd0;
			held_l   = 8'd0;
			held_r   = 8'd0;
			row_idx  = 8'd0;
			row_held = 1'b0;
			frames_closed++;
		end else begin
			held_l   = r.left_col;
			held_r   = r.right_col;
			row_idx  = next_idx;
			row_held = 1'b1;
		end
	endtask

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// driver: feeds accepted items to the shadow, presents items from the pending queue, holds a stalled item steady
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				filter_row('{left_edge, right_edge, frame_end});
				rows_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					edge_row_t nxt;
					nxt = pending_rows.pop_front();
					in_valid   <= 1'b1;
					left_edge  <= nxt.left_col;
					right_edge <= nxt.right_col;
					frame_end  <= nxt.last_in_frame;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every accepted result and drives the receiver's stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_rows.size() == 0) begin
					flag_error($sformatf("result with nothing expected: row %0d l %0d r %0d last %0b",
						row_number, left_filtered, right_filtered, last_row));
				end else begin
					esf_pkg::result_t want;
					want = expected_rows.pop_front();
					rows_checked++;
					if (row_number !== want.row_number || left_filtered !== want.left_filtered ||
							right_filtered !== want.right_filtered || last_row !== want.last_row)
						flag_error($sformatf(
							"expected row %0d l %0d r %0d last %0b, got row %0d l %0d r %0d last %0b",
							want.row_number, want.left_filtered, want.right_filtered, want.last_row,
							row_number, left_filtered, right_filtered, last_row));
				end
			end
			// a requested hold-off is counted out here, independent of the sender
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (holds_done != hold_requests) begin
				holds_done <= holds_done + 1;
				hold_left  <= LONG_HOLD - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog: the run is stuck if no item moves on either side for too long
	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_rows.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_row(input logic [7:0] l, input logic [7:0] r, input logic fe);
		pending_rows.push_back('{l, r, fe});
	endtask

	// random walk along a track edge with occasional spikes of any size
	function automatic logic [7:0] next_col(inout logic [7:0] base);
		int         pick;
		logic [7:0] jump;
		pick = $urandom_range(99);
		if (pick < 15) begin
			jump = (pick < 8) ? 8'($urandom_range(40, 1)) : 8'($urandom_range(255, 41));
			return $urandom_range(1) ? base + jump : base - jump;
		end
		if (pick < 22)
			base = 8'($urandom_range(255));
		else
			base = base + 8'($urandom_range(6)) - 8'd3;
		return base;
	endfunction

	task automatic push_frame(input int rows);
		logic [7:0] base_l;
		logic [7:0] base_r;
		base_l = 8'($urandom_range(255));
		base_r = 8'($urandom_range(255));
		for (int i = 0; i < rows; i++)
			queue_row(next_col(base_l), next_col(base_r), i == rows - 1);
	endtask

	// whole frames of random length until the row budget is spent
	task automatic push_frames(input int budget);
		int len;
		while (budget > 0) begin
			len = $urandom_range(60, 1);
			if (len > budget)
				len = budget;
			push_frame(len);
			budget -= len;
		end
	endtask

	// wait until the sender side is quiet and every expected result is back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_rows.size() != 0 || in_valid || expected_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		thr_shadow = v;
		thr_writes++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at the reset threshold
		// single-row frame: queued at its accept, unfiltered
		queue_row(8'd0, 8'd255, 1'b1);
		// spike below the window, a peak, a valley, then a step exactly at the threshold
		queue_row(8'd100, 8'd150, 1'b0);
		queue_row(8'd100, 8'd150, 1'b0);
		queue_row(8'd100, 8'd150, 1'b0);
		queue_row(8'd180, 8'd150, 1'b0);
		queue_row(8'd200, 8'd150, 1'b0);
		queue_row(8'd100, 8'd0, 1'b0);
		queue_row(8'd105, 8'd150, 1'b0);
		queue_row(8'd100, 8'd150, 1'b1);
		// full-scale peak and valley between the rails
		queue_row(8'd0, 8'd255, 1'b0);
		queue_row(8'd0, 8'd255, 1'b0);
		queue_row(8'd0, 8'd255, 1'b0);
		queue_row(8'd0, 8'd255, 1'b0);
		queue_row(8'd255, 8'd0, 1'b0);
		queue_row(8'd0, 8'd255, 1'b0);
		queue_row(8'd0, 8'd254, 1'b1);
		queue_row(8'd255, 8'd0, 1'b1);
		push_frames(80);
		wait_drained();

		// threshold zero, sender idling, and a long receiver hold to back up the block
		write_threshold(8'd0);
		send_idle_pct = 48;
		push_frames(90);
		hold_requests++;
		wait_drained();

		// threshold at full scale: nothing can be replaced; receiver stalling
		write_threshold(8'd255);
		send_idle_pct = 0;
		stall_pct     = 48;
		push_frames(40);
		wait_drained();
		push_frames(40);
		wait_drained();

		// one long frame so the row count saturates, light idling on both sides
		write_threshold(8'($urandom_range(40, 1)));
		send_idle_pct = 8;
		stall_pct     = 8;
		push_frame(260);
		wait_drained();

		// closing stretch, random threshold, no idling
		write_threshold(8'($urandom_range(255)));
		send_idle_pct = 0;
		stall_pct     = 0;
		push_frames(50);
		wait_drained();

		if (expected_rows.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_rows.size()));
		$display("rows sent %0d in %0d frames, results checked %0d, columns despiked %0d",
			rows_sent, frames_closed, rows_checked, despiked);
		$display("threshold writes %0d across five idle and stall mixes, errors %0d",
			thr_writes, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
